// ===== hw/rtl/rpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpfr_pkg
// Shared types, geometry constants and command codes for the rotated page
// framebuffer raster unit.
// ----------------------------------------------------------------------------
package rpfr_pkg;

    // Panel geometry, physical orientation
    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_ROWS    = 64;
    localparam int PAGES         = PANEL_ROWS / 8;
    localparam int STORE_BYTES   = PANEL_COLUMNS * PAGES;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int COL_W  = $clog2(PANEL_COLUMNS);
    localparam int ROW_W  = $clog2(PANEL_ROWS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int POS_W    = 9;
    localparam int BIDX_W   = 10;
    localparam int DATA_W   = 8;
    localparam int COORD_W  = 11;   // holds pos + width - 1 without overflow
    localparam int RECT_N   = 4;    // rectangle outline needs four strips
    localparam int RSEL_W   = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] BG_BYTE = 8'hff;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HLINE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VLINE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RECT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FILL  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd6;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord X_MAX = t_coord'(PANEL_ROWS - 1);
    localparam t_coord Y_MAX = t_coord'(PANEL_COLUMNS - 1);

    typedef enum logic [1:0] {
        K_CLEAR,
        K_DRAW,
        K_READ,
        K_NOP
    } t_kind;

    // Portrait rectangle, inclusive bounds, not yet clipped
    typedef struct packed {
        t_coord x0;
        t_coord x1;
        t_coord y0;
        t_coord y1;
    } t_rect;

    typedef struct packed {
        t_kind                     kind;
        logic [MODE_W-1:0]         mode;
        logic                      on;
        logic [RECT_N-1:0]         rvld;
        t_rect [RECT_N-1:0]        rects;
        logic [BIDX_W-1:0]         byte_idx;
    } t_cmd;

    // Finished command from back end to output register
    typedef struct packed {
        logic                valid;
        logic [DATA_W-1:0]   data;
        logic [MODE_W-1:0]   mode;
    } t_done;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_READ,
        S_RWAIT,
        S_DONE
    } t_back_state;

endpackage

// ===== hw/rtl/rpfr_ram.sv =====
// ----------------------------------------------------------------------------
// rpfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rpfr_front.sv =====
// ----------------------------------------------------------------------------
// rpfr_front
// Accepts drawing beats and turns each into a command: clear, read, no-op,
// or a draw made of up to four portrait rectangles.
// ----------------------------------------------------------------------------
module rpfr_front (
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rpfr_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_end_or_width,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_rect_height,
    input  logic                                i_pixel_on,
    input  logic [rpfr_pkg::BIDX_W-1:0]         i_byte_index,
    input  logic                                i_q_full,
    input  logic                                i_init_busy,
    output logic                                o_push,
    output rpfr_pkg::t_cmd                      o_cmd
);

    rpfr_pkg::t_coord px, py, ew, rh, xe, ye, lo_x, hi_x, lo_y, hi_y;
    logic             rect_ok;

    // Sign-extend and derive far edges
    always_comb begin
        px      = rpfr_pkg::t_coord'(i_pos_x);
        py      = rpfr_pkg::t_coord'(i_pos_y);
        ew      = rpfr_pkg::t_coord'(i_end_or_width);
        rh      = rpfr_pkg::t_coord'(i_rect_height);
        xe      = px + ew - rpfr_pkg::t_coord'(1);
        ye      = py + rh - rpfr_pkg::t_coord'(1);
        rect_ok = (ew > rpfr_pkg::t_coord'(0)) && (rh > rpfr_pkg::t_coord'(0));
        // ordered line ends
        lo_x    = (px > ew) ? ew : px;
        hi_x    = (px > ew) ? px : ew;
        lo_y    = (py > ew) ? ew : py;
        hi_y    = (py > ew) ? py : ew;
    end

    // Classify
    always_comb begin
        o_cmd          = '0;
        o_cmd.mode     = i_mode;
        o_cmd.on       = i_pixel_on;
        o_cmd.byte_idx = i_byte_index;
        o_cmd.kind     = rpfr_pkg::K_NOP;
        case (i_mode)
            rpfr_pkg::MODE_CLEAR: begin
                o_cmd.kind = rpfr_pkg::K_CLEAR;
            end
            rpfr_pkg::MODE_PIXEL: begin
                o_cmd.kind     = rpfr_pkg::K_DRAW;
                o_cmd.rvld     = 4'b0001;
                o_cmd.rects[0] = '{x0: px, x1: px, y0: py, y1: py};
            end
            rpfr_pkg::MODE_HLINE: begin
                o_cmd.kind     = rpfr_pkg::K_DRAW;
                o_cmd.rvld     = 4'b0001;
                o_cmd.rects[0] = '{x0: lo_x, x1: hi_x, y0: py, y1: py};
            end
            rpfr_pkg::MODE_VLINE: begin
                o_cmd.kind     = rpfr_pkg::K_DRAW;
                o_cmd.rvld     = 4'b0001;
                o_cmd.rects[0] = '{x0: px, x1: px, y0: lo_y, y1: hi_y};
            end
            rpfr_pkg::MODE_RECT: begin
                // overlapping corners are harmless: same value written twice
                o_cmd.kind     = rpfr_pkg::K_DRAW;
                o_cmd.rvld     = rect_ok ? 4'b1111 : 4'b0000;
                o_cmd.rects[0] = '{x0: px, x1: xe, y0: py, y1: py};
                o_cmd.rects[1] = '{x0: px, x1: xe, y0: ye, y1: ye};
                o_cmd.rects[2] = '{x0: px, x1: px, y0: py, y1: ye};
                o_cmd.rects[3] = '{x0: xe, x1: xe, y0: py, y1: ye};
            end
            rpfr_pkg::MODE_FILL: begin
                o_cmd.kind     = rpfr_pkg::K_DRAW;
                o_cmd.rvld     = rect_ok ? 4'b0001 : 4'b0000;
                o_cmd.rects[0] = '{x0: px, x1: xe, y0: py, y1: ye};
            end
            rpfr_pkg::MODE_READ: begin
                o_cmd.kind = rpfr_pkg::K_READ;
            end
            default: begin
                o_cmd.kind = rpfr_pkg::K_NOP;
            end
        endcase
    end

    assign o_in_stall = i_q_full || i_init_busy;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

// ===== hw/rtl/rpfr_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// rpfr_cmd_queue
// Short FIFO of decoded commands between the front and the back end.
// ----------------------------------------------------------------------------
module rpfr_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpfr_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output rpfr_pkg::t_cmd  o_cmd
);

    rpfr_pkg::t_cmd                   r_mem [rpfr_pkg::QUEUE_DEPTH];
    logic [rpfr_pkg::QPTR_W-1:0]      r_wp, r_rp, n_wp, n_rp;
    logic [rpfr_pkg::QCNT_W-1:0]      r_count, n_count;
    logic                             do_push, do_pop;

    localparam logic [rpfr_pkg::QPTR_W-1:0] PTR_LAST =
        rpfr_pkg::QPTR_W'(rpfr_pkg::QUEUE_DEPTH - 1);
    localparam logic [rpfr_pkg::QCNT_W-1:0] CNT_FULL =
        rpfr_pkg::QCNT_W'(rpfr_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and count update
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/rpfr_back.sv =====
// ----------------------------------------------------------------------------
// rpfr_back
// Back end: owns the framebuffer RAM, runs the clearing sweep, clips each
// rectangle and walks its bytes page by page with read-modify-write.
// ----------------------------------------------------------------------------
module rpfr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_msb_first,
    input  logic            i_q_valid,
    input  rpfr_pkg::t_cmd  i_q_cmd,
    output logic            o_pop,
    output logic            o_init_busy,
    output rpfr_pkg::t_done o_done,
    input  logic            i_done_ack
);

    localparam logic [rpfr_pkg::ADDR_W-1:0] ADDR_LAST =
        rpfr_pkg::ADDR_W'(rpfr_pkg::STORE_BYTES - 1);
    localparam logic [rpfr_pkg::ROW_W-1:0] ROW_LAST =
        rpfr_pkg::ROW_W'(rpfr_pkg::PANEL_ROWS - 1);

    rpfr_pkg::t_back_state               r_state, n_state;
    logic                                r_init, n_init;
    logic [rpfr_pkg::ADDR_W-1:0]         r_clr_addr, n_clr_addr;
    logic                                r_wr_vld, n_wr_vld;
    logic [rpfr_pkg::ADDR_W-1:0]         r_wr_addr, n_wr_addr;
    logic [rpfr_pkg::DATA_W-1:0]         r_wr_mask, n_wr_mask;
    rpfr_pkg::t_cmd                      r_cmd, n_cmd;
    logic [rpfr_pkg::RECT_N-1:0]         r_rmask, n_rmask;
    logic [rpfr_pkg::PAGE_W-1:0]         r_page, n_page;
    logic [rpfr_pkg::PAGE_W-1:0]         r_pg_first, n_pg_first;
    logic [rpfr_pkg::PAGE_W-1:0]         r_pg_last, n_pg_last;
    logic [2:0]                          r_lo_bit, n_lo_bit;
    logic [2:0]                          r_hi_bit, n_hi_bit;
    logic [rpfr_pkg::COL_W-1:0]          r_col, n_col;
    logic [rpfr_pkg::COL_W-1:0]          r_col0, n_col0;
    logic [rpfr_pkg::COL_W-1:0]          r_col1, n_col1;
    logic [rpfr_pkg::DATA_W-1:0]         r_res_data, n_res_data;

    // RAM port signals
    logic                                ram_we;
    logic [rpfr_pkg::ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [rpfr_pkg::DATA_W-1:0]         ram_wdata, ram_rdata;

    // Setup-time clip results
    logic [rpfr_pkg::RSEL_W-1:0]         sel;
    rpfr_pkg::t_rect                     rsel;
    rpfr_pkg::t_coord                    cx0, cx1, cy0, cy1;
    logic                                empty;
    logic [rpfr_pkg::ROW_W-1:0]          row_lo, row_hi;

    // Walk signals
    logic [rpfr_pkg::ADDR_W-1:0]         walk_addr;
    logic [2:0]                          lo, hi;
    logic [rpfr_pkg::DATA_W-1:0]         mask_lsb, page_mask;
    logic                                in_range;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    rpfr_ram #(
        .WIDTH (rpfr_pkg::DATA_W),
        .DEPTH (rpfr_pkg::STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Pick the lowest pending rectangle and clip it to the panel
    always_comb begin
        if (r_rmask[0]) begin
            sel = 2'd0;
        end else if (r_rmask[1]) begin
            sel = 2'd1;
        end else if (r_rmask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        rsel   = r_cmd.rects[sel];
        cx0    = (rsel.x0 < rpfr_pkg::t_coord'(0)) ? rpfr_pkg::t_coord'(0) : rsel.x0;
        cx1    = (rsel.x1 > rpfr_pkg::X_MAX) ? rpfr_pkg::X_MAX : rsel.x1;
        cy0    = (rsel.y0 < rpfr_pkg::t_coord'(0)) ? rpfr_pkg::t_coord'(0) : rsel.y0;
        cy1    = (rsel.y1 > rpfr_pkg::Y_MAX) ? rpfr_pkg::Y_MAX : rsel.y1;
        empty  = (cx0 > cx1) || (cy0 > cy1);
        // portrait x maps to physical row PANEL_ROWS-1-x
        row_lo = ROW_LAST - rpfr_pkg::ROW_W'(cx1);
        row_hi = ROW_LAST - rpfr_pkg::ROW_W'(cx0);
    end

    // Byte address and bit mask for the current page/column
    always_comb begin
        walk_addr = rpfr_pkg::ADDR_W'(
            rpfr_pkg::ADDR_W'(r_page) * rpfr_pkg::ADDR_W'(rpfr_pkg::PANEL_COLUMNS)
            + rpfr_pkg::ADDR_W'(r_col));
        lo        = (r_page == r_pg_first) ? r_lo_bit : 3'd0;
        hi        = (r_page == r_pg_last) ? r_hi_bit : 3'd7;
        mask_lsb  = (8'hff << lo) & (8'hff >> (3'd7 - hi));
        page_mask = i_msb_first ? rev8(mask_lsb) : mask_lsb;
        in_range  = (32'(r_cmd.byte_idx) < rpfr_pkg::STORE_BYTES);
    end

    // Next state and outputs
    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_clr_addr = r_clr_addr;
        n_wr_vld   = 1'b0;
        n_wr_addr  = r_wr_addr;
        n_wr_mask  = r_wr_mask;
        n_cmd      = r_cmd;
        n_rmask    = r_rmask;
        n_page     = r_page;
        n_pg_first = r_pg_first;
        n_pg_last  = r_pg_last;
        n_lo_bit   = r_lo_bit;
        n_hi_bit   = r_hi_bit;
        n_col      = r_col;
        n_col0     = r_col0;
        n_col1     = r_col1;
        n_res_data = r_res_data;
        o_pop      = 1'b0;

        // write half of the read-modify-write lands in the cycle after the read
        ram_we    = r_wr_vld;
        ram_waddr = r_wr_addr;
        ram_wdata = r_cmd.on ? (ram_rdata & ~r_wr_mask) : (ram_rdata | r_wr_mask);
        ram_raddr = walk_addr;

        case (r_state)
            rpfr_pkg::S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = rpfr_pkg::BG_BYTE;
                if (r_clr_addr == ADDR_LAST) begin
                    n_clr_addr = '0;
                    n_init     = 1'b0;
                    n_state    = r_init ? rpfr_pkg::S_IDLE : rpfr_pkg::S_DONE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            rpfr_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_q_cmd;
                    n_rmask    = i_q_cmd.rvld;
                    n_res_data = '0;
                    n_clr_addr = '0;
                    case (i_q_cmd.kind)
                        rpfr_pkg::K_CLEAR: n_state = rpfr_pkg::S_CLR;
                        rpfr_pkg::K_DRAW:  n_state = rpfr_pkg::S_SETUP;
                        rpfr_pkg::K_READ:  n_state = rpfr_pkg::S_READ;
                        default:           n_state = rpfr_pkg::S_DONE;
                    endcase
                end
            end
            rpfr_pkg::S_SETUP: begin
                if (r_rmask == '0) begin
                    n_state = rpfr_pkg::S_DONE;
                end else begin
                    n_rmask[sel] = 1'b0;
                    if (!empty) begin
                        n_pg_first = rpfr_pkg::PAGE_W'(row_lo >> 3);
                        n_pg_last  = rpfr_pkg::PAGE_W'(row_hi >> 3);
                        n_page     = rpfr_pkg::PAGE_W'(row_lo >> 3);
                        n_lo_bit   = row_lo[2:0];
                        n_hi_bit   = row_hi[2:0];
                        n_col0     = rpfr_pkg::COL_W'(cy0);
                        n_col1     = rpfr_pkg::COL_W'(cy1);
                        n_col      = rpfr_pkg::COL_W'(cy0);
                        n_state    = rpfr_pkg::S_RUN;
                    end
                end
            end
            rpfr_pkg::S_RUN: begin
                // read this byte now, modify and write it next cycle
                n_wr_vld  = 1'b1;
                n_wr_addr = walk_addr;
                n_wr_mask = page_mask;
                if (r_col == r_col1) begin
                    if (r_page == r_pg_last) begin
                        n_state = (r_rmask == '0) ? rpfr_pkg::S_DONE : rpfr_pkg::S_SETUP;
                    end else begin
                        n_page = r_page + 1'b1;
                        n_col  = r_col0;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            rpfr_pkg::S_READ: begin
                ram_raddr = rpfr_pkg::ADDR_W'(r_cmd.byte_idx);
                n_state   = rpfr_pkg::S_RWAIT;
            end
            rpfr_pkg::S_RWAIT: begin
                n_res_data = in_range ? ram_rdata : '0;
                n_state    = rpfr_pkg::S_DONE;
            end
            rpfr_pkg::S_DONE: begin
                if (i_done_ack) begin
                    n_state = rpfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpfr_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rpfr_pkg::S_CLR;
            r_init     <= 1'b1;
            r_clr_addr <= '0;
            r_wr_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_clr_addr <= n_clr_addr;
            r_wr_vld   <= n_wr_vld;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_wr_mask  <= n_wr_mask;
        r_cmd      <= n_cmd;
        r_rmask    <= n_rmask;
        r_page     <= n_page;
        r_pg_first <= n_pg_first;
        r_pg_last  <= n_pg_last;
        r_lo_bit   <= n_lo_bit;
        r_hi_bit   <= n_hi_bit;
        r_col      <= n_col;
        r_col0     <= n_col0;
        r_col1     <= n_col1;
        r_res_data <= n_res_data;
    end

    assign o_init_busy = r_init;
    assign o_done.valid = (r_state == rpfr_pkg::S_DONE);
    assign o_done.data  = r_res_data;
    assign o_done.mode  = r_cmd.mode;

    // Walk never runs past the clipped bounds
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpfr_pkg::S_RUN) |-> (r_col <= r_col1 && r_page <= r_pg_last))
        else $error("walk past clipped bounds");

    // Every walked byte schedules its write-back
    a_run_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpfr_pkg::S_RUN) |=> r_wr_vld)
        else $error("missing write-back after read");

    // Clearing sweep owns the write port alone
    a_clr_no_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpfr_pkg::S_CLR) |-> !r_wr_vld)
        else $error("write-back collides with clear sweep");

    // Byte read sees all earlier writes
    a_read_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpfr_pkg::S_READ) |-> !r_wr_vld)
        else $error("byte read races a pending write");

endmodule

// ===== hw/rtl/rotated_page_framebuffer_raster_unit.sv =====
// ----------------------------------------------------------------------------
// rotated_page_framebuffer_raster_unit
// Draws portrait-coordinate shapes into a 128x64 page-organized one-bit
// framebuffer and reads back single bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one drawing command per
//   beat; output channel (o_out_valid / i_out_stall) returns one beat per
//   command with the read byte (zero unless read mode) and the mode echo.
//   i_cfg_we / i_cfg_wdata set the bit order (msb_first); write it only
//   while the block is idle.
// Timing:
//   The framebuffer RAM has one write and one read port, so drawing moves
//   one byte per cycle while it walks a rectangle. An accepted command is
//   queued, popped by the idle back end and handed to the output register
//   when finished; a draw adds one setup step per rectangle and one step per
//   touched byte (pages x columns); a draw that ends on a clipped-away
//   rectangle, or has none, adds one more setup step. Rectangle outlines run
//   four strips. Clear sweeps every byte; a byte read takes a wait state.
//   A two-entry command queue lets new beats be accepted while the back end
//   draws; the output register holds a finished result while the receiver
//   stalls, and the back end waits on it before taking the next command.
// Reset:
//   Synchronous, active low. After reset a sweep fills the whole buffer
//   with 0xff; o_in_stall is high until it ends.
// ----------------------------------------------------------------------------
module rotated_page_framebuffer_raster_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rpfr_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_end_or_width,
    input  logic signed [rpfr_pkg::POS_W-1:0]   i_rect_height,
    input  logic                                i_pixel_on,
    input  logic [rpfr_pkg::BIDX_W-1:0]         i_byte_index,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rpfr_pkg::DATA_W-1:0]         o_read_data,
    output logic [rpfr_pkg::MODE_W-1:0]         o_done_mode
);

    logic                          r_msb_first;
    logic                          r_out_valid;
    logic [rpfr_pkg::DATA_W-1:0]   r_out_data;
    logic [rpfr_pkg::MODE_W-1:0]   r_out_mode;

    logic                          push, pop, q_valid, q_full, init_busy, out_free;
    rpfr_pkg::t_cmd                push_cmd, head_cmd;
    rpfr_pkg::t_done               done;

    rpfr_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_end_or_width (i_end_or_width),
        .i_rect_height  (i_rect_height),
        .i_pixel_on     (i_pixel_on),
        .i_byte_index   (i_byte_index),
        .i_q_full       (q_full),
        .i_init_busy    (init_busy),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    rpfr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    rpfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_msb_first (r_msb_first),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_done      (done),
        .i_done_ack  (out_free)
    );

    // Bit order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first <= 1'b0;
        end else if (i_cfg_we) begin
            r_msb_first <= i_cfg_wdata;
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && done.valid) begin
            r_out_data <= done.data;
            r_out_mode <= done.mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_done_mode = r_out_mode;

endmodule

// ===== tb/rotated_page_framebuffer_raster_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rotated_page_framebuffer_raster_unit_tb
// Self-checking bench for the rotated page framebuffer raster unit. It keeps
// a shadow copy of the page framebuffer and the bit-order register, and
// predicts the read byte and the mode echo of every accepted command. The
// run starts with directed drawing and readback, then random command mixes
// under both bit orders. Both channels idle in random bursts, the result
// side holds off for a long stretch once, and the tail runs back to back.
// ----------------------------------------------------------------------------
module rotated_page_framebuffer_raster_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpfr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_SHOWN        = 10;
    localparam int DRAIN_LIMIT      = 200000;
    localparam int TAIL_CYCLES      = 64;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  end_or_width;
        logic signed [POS_W-1:0]  rect_height;
        logic                     pixel_on;
        logic [BIDX_W-1:0]        byte_index;
    } raster_cmd_t;

    typedef struct {
        logic [DATA_W-1:0]  read_data;
        logic [MODE_W-1:0]  done_mode;
    } raster_result_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic                     i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [MODE_W-1:0]        i_mode;
    logic signed [POS_W-1:0]  i_pos_x;
    logic signed [POS_W-1:0]  i_pos_y;
    logic signed [POS_W-1:0]  i_end_or_width;
    logic signed [POS_W-1:0]  i_rect_height;
    logic                     i_pixel_on;
    logic [BIDX_W-1:0]        i_byte_index;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [DATA_W-1:0]        o_read_data;
    logic [MODE_W-1:0]        o_done_mode;

    // shadow framebuffer and bit-order register
    logic [DATA_W-1:0]  shadow_fb [0:STORE_BYTES-1];
    logic               shadow_msb_first;

    raster_result_t     pending_results [$];
    raster_result_t     want_beat;
    int                 error_count;
    bit                 quiet_run;
    bit                 long_hold_req;

    rotated_page_framebuffer_raster_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_end_or_width (i_end_or_width),
        .i_rect_height  (i_rect_height),
        .i_pixel_on     (i_pixel_on),
        .i_byte_index   (i_byte_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_done_mode    (o_done_mode)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // one portrait pixel; clipped pixels are dropped
    function automatic void plot_pixel(int x, int y, logic on);
        int row;
        int idx;
        int bitpos;
        if (x < 0 || x >= PANEL_ROWS || y < 0 || y >= PANEL_COLUMNS) return;
        row    = PANEL_ROWS - 1 - x;
        idx    = (row / 8) * PANEL_COLUMNS + y;
        bitpos = shadow_msb_first ? 7 - (row % 8) : row % 8;
        shadow_fb[idx][bitpos] = ~on;
    endfunction

    // portrait x span at fixed y, ends swapped if reversed
    function automatic void span_x(int a, int b, int y, logic on);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        for (int x = lo; x <= hi; x++) plot_pixel(x, y, on);
    endfunction

    function automatic void span_y(int x, int a, int b, logic on);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        for (int y = lo; y <= hi; y++) plot_pixel(x, y, on);
    endfunction

    // applies one command to the shadow buffer, returns its result beat
    function automatic raster_result_t apply_raster_cmd(raster_cmd_t c);
        raster_result_t r;
        int px;
        int py;
        int ew;
        int rh;
        px = int'(c.pos_x);
        py = int'(c.pos_y);
        ew = int'(c.end_or_width);
        rh = int'(c.rect_height);
        r.read_data = '0;
        r.done_mode = c.mode;
        case (c.mode)
            MODE_CLEAR: begin
                for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = BG_BYTE;
            end
            MODE_PIXEL: plot_pixel(px, py, c.pixel_on);
            MODE_HLINE: span_x(px, ew, py, c.pixel_on);
            MODE_VLINE: span_y(px, py, ew, c.pixel_on);
            MODE_RECT: begin
                if (ew > 0 && rh > 0) begin
                    span_x(px, px + ew - 1, py, c.pixel_on);
                    span_x(px, px + ew - 1, py + rh - 1, c.pixel_on);
                    span_y(px, py, py + rh - 1, c.pixel_on);
                    span_y(px + ew - 1, py, py + rh - 1, c.pixel_on);
                end
            end
            MODE_FILL: begin
                if (ew > 0 && rh > 0) begin
                    for (int y = py; y < py + rh; y++)
                        span_x(px, px + ew - 1, y, c.pixel_on);
                end
            end
            MODE_READ: begin
                if (int'(c.byte_index) < STORE_BYTES) r.read_data = shadow_fb[c.byte_index];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic raster_cmd_t draw_cmd(logic [MODE_W-1:0] mode, int x, int y,
                                             int e, int h, logic on, int idx);
        raster_cmd_t c;
        c.mode         = mode;
        c.pos_x        = POS_W'(x);
        c.pos_y        = POS_W'(y);
        c.end_or_width = POS_W'(e);
        c.rect_height  = POS_W'(h);
        c.pixel_on     = on;
        c.byte_index   = BIDX_W'(idx);
        return c;
    endfunction

    // store byte holding portrait pixel x,y (in range)
    function automatic int byte_of(int x, int y);
        return ((PANEL_ROWS - 1 - x) / 8) * PANEL_COLUMNS + y;
    endfunction

    // mostly near the panel, sometimes anywhere in the 9-bit range
    function automatic logic signed [POS_W-1:0] pick_coord(int span);
        if ($urandom_range(0, 4) == 0) return POS_W'($urandom);
        return POS_W'(int'($urandom_range(0, span + 7)) - 4);
    endfunction

    // mostly small extents, few medium, rare full range
    function automatic logic signed [POS_W-1:0] pick_extent();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 17) return POS_W'(int'($urandom_range(0, 14)) - 2);
        if (sel < 19) return POS_W'($urandom_range(1, 64));
        return POS_W'($urandom);
    endfunction

    function automatic raster_cmd_t random_cmd();
        raster_cmd_t c;
        int sel;
        sel            = $urandom_range(0, 99);
        c.pos_x        = pick_coord(PANEL_ROWS);
        c.pos_y        = pick_coord(PANEL_COLUMNS);
        c.end_or_width = POS_W'($urandom);
        c.rect_height  = POS_W'($urandom);
        c.pixel_on     = 1'($urandom);
        c.byte_index   = BIDX_W'($urandom);
        if (sel < 2) begin
            c.mode = MODE_CLEAR;
        end else if (sel < 5) begin
            c.mode = MODE_UNUSED;
        end else if (sel < 35) begin
            c.mode = MODE_READ;
            if ($urandom_range(0, 9) < 7)
                c.byte_index = BIDX_W'(byte_of($urandom_range(0, PANEL_ROWS - 1),
                                                $urandom_range(0, PANEL_COLUMNS - 1)));
        end else if (sel < 50) begin
            c.mode = MODE_PIXEL;
        end else if (sel < 62) begin
            c.mode         = MODE_HLINE;
            c.end_or_width = pick_coord(PANEL_ROWS);
        end else if (sel < 74) begin
            c.mode         = MODE_VLINE;
            c.end_or_width = pick_coord(PANEL_COLUMNS);
        end else begin
            c.mode         = (sel < 87) ? MODE_RECT : MODE_FILL;
            c.end_or_width = pick_extent();
            c.rect_height  = pick_extent();
        end
        return c;
    endfunction

    // one command beat; valid stays up when the next beat follows directly
    task automatic send_cmd(input raster_cmd_t c);
        int gap;
        gap = 0;
        if (!quiet_run && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= c.mode;
        i_pos_x        <= c.pos_x;
        i_pos_y        <= c.pos_y;
        i_end_or_width <= c.end_or_width;
        i_rect_height  <= c.rect_height;
        i_pixel_on     <= c.pixel_on;
        i_byte_index   <= c.byte_index;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_raster_cmd(c));
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain_results();
        i_in_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++)
            @(posedge i_clk);
    endtask

    // bit-order register write, with no command outstanding
    task automatic write_bit_order(input logic msb_first);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= msb_first;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_msb_first = msb_first;
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN) $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result beat with nothing expected: data %02h mode %0d",
                                     o_read_data, o_done_mode));
            end else begin
                want_beat = pending_results.pop_front();
                if (o_read_data !== want_beat.read_data)
                    flag_error($sformatf("read_data expected %02h got %02h (mode %0d)",
                                         want_beat.read_data, o_read_data,
                                         want_beat.done_mode));
                if (o_done_mode !== want_beat.done_mode)
                    flag_error($sformatf("done_mode expected %0d got %0d",
                                         want_beat.done_mode, o_done_mode));
            end
        end
    end

    // result-side stall: random bursts, one long hold on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end else if (!quiet_run && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every mode, clipping, reversed ends, empty rectangles, LSB-first order
    task automatic test_directed_modes();
        write_bit_order(1'b0);
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, 0));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
        send_cmd(draw_cmd(MODE_PIXEL, 0, 0, -256, 255, 1'b1, 1023));
        send_cmd(draw_cmd(MODE_PIXEL, PANEL_ROWS - 1, PANEL_COLUMNS - 1, 0, 0, 1'b1, 0));
        // clipped pixels on each edge and at the field extremes
        send_cmd(draw_cmd(MODE_PIXEL, -1, 5, 0, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_PIXEL, PANEL_ROWS, 5, 0, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_PIXEL, 5, -1, 0, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_PIXEL, 5, PANEL_COLUMNS, 0, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_PIXEL, -256, 255, 255, -256, 1'b1, 0));
        // reversed line ends, outline, fill, empty rectangles
        send_cmd(draw_cmd(MODE_HLINE, 20, 10, 3, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_VLINE, 30, 100, 90, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_RECT,  40, 40, 6, 5, 1'b1, 0));
        send_cmd(draw_cmd(MODE_FILL,  8, 60, 10, 12, 1'b1, 0));
        send_cmd(draw_cmd(MODE_FILL,  8, 60, 0, 5, 1'b0, 0));
        send_cmd(draw_cmd(MODE_RECT,  40, 40, 4, -3, 1'b0, 0));
        send_cmd(draw_cmd(MODE_FILL,  -256, -256, 255, 255, 1'b1, 0));
        send_cmd(draw_cmd(MODE_PIXEL, 0, 0, 0, 0, 1'b0, 0));
        send_cmd(draw_cmd(MODE_UNUSED, 3, 3, 3, 3, 1'b1, 511));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(20, 10)));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(30, 95)));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(44, 42)));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(8, 60)));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(PANEL_ROWS - 1, 127)));
        send_cmd(draw_cmd(MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(8, 60)));
        drain_results();
    endtask

    // MSB-first order and full-panel fill
    task automatic test_bit_order();
        write_bit_order(1'b1);
        send_cmd(draw_cmd(MODE_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_HLINE, 0, 7, PANEL_ROWS - 1, 0, 1'b1, 0));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(0, 0)));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(33, 7)));
        send_cmd(draw_cmd(MODE_FILL,  0, 0, 255, 255, 1'b1, 0));
        send_cmd(draw_cmd(MODE_PIXEL, 9, 64, 0, 0, 1'b0, 0));
        send_cmd(draw_cmd(MODE_READ,  0, 0, 0, 0, 1'b0, byte_of(9, 64)));
        drain_results();
    endtask

    // random command mix under one bit order, pausing midway until drained
    task automatic test_random_mix(input int count, input logic msb_first);
        drain_results();
        write_bit_order(msb_first);
        for (int i = 0; i < count; i++) begin
            send_cmd(random_cmd());
            if (i == count / 2) drain_results();
        end
    endtask

    // long result hold while commands keep coming, so the input stalls
    task automatic test_output_backpressure();
        drain_results();
        long_hold_req = 1'b1;
        // keep offering until the hold has run its course
        for (int i = 0; i < 16 || long_hold_req; i++) send_cmd(random_cmd());
        drain_results();
    endtask

    // final stretch without idling on either side
    task automatic test_back_to_back_tail(input int count);
        drain_results();
        write_bit_order(1'b0);
        quiet_run = 1'b1;
        for (int i = 0; i < count; i++) send_cmd(random_cmd());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        error_count      = 0;
        quiet_run        = 1'b0;
        long_hold_req    = 1'b0;
        shadow_msb_first = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = BG_BYTE;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= 1'b0;
        i_in_valid     <= 1'b0;
        i_mode         <= MODE_CLEAR;
        i_pos_x        <= '0;
        i_pos_y        <= '0;
        i_end_or_width <= '0;
        i_rect_height  <= '0;
        i_pixel_on     <= 1'b0;
        i_byte_index   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_modes();
        test_bit_order();
        test_random_mix(250, 1'b1);
        test_random_mix(250, 1'b0);
        test_output_backpressure();
        test_random_mix(220, 1'b1);
        test_back_to_back_tail(80);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d result beats never arrived", pending_results.size()));

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
